### hdl/xbr_pkg.sv
package xbr_pkg;

   // Request codes
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_BYTE  = 1'b1;

   // Result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_TX      = 1'b1;

   // Protocol characters
   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_C   = 8'h43;

   // Verdict codes
   localparam logic [2:0] VERDICT_NONE   = 3'd0;
   localparam logic [2:0] VERDICT_COMMIT = 3'd1;
   localparam logic [2:0] VERDICT_DUP    = 3'd2;
   localparam logic [2:0] VERDICT_NAK    = 3'd3;
   localparam logic [2:0] VERDICT_ABORT  = 3'd4;
   localparam logic [2:0] VERDICT_END    = 3'd5;

   localparam int COUNT_W = 10;
   localparam logic [COUNT_W:0] SMALL_PAYLOAD = 11'd128;
   localparam logic [COUNT_W:0] LARGE_PAYLOAD = 11'd1024;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_WAIT = 3'd1,
      PH_NUM  = 3'd2,
      PH_COMP = 3'd3,
      PH_DATA = 3'd4,
      PH_CRCH = 3'd5,
      PH_CRCL = 3'd6
   } phase_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic               out_kind;
      logic [7:0]         out_byte;
      logic [COUNT_W-1:0] payload_index;
      logic [2:0]         verdict;
      logic [7:0]         block_number;
   } rsp_item_type;

   // Result of one processing step: a flag and the transaction it produces.
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } step_result_type;

   // CRC-16/XMODEM, one byte, MSB first.
   function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### hdl/xbr_input_reg.sv
module xbr_input_reg
   import xbr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   input  logic         advance,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### hdl/xbr_session_core.sv
module xbr_session_core
   import xbr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  req_item_type    item,
   output step_result_type result
);

   phase_type          phase_ff, phase_in;
   logic [7:0]         last_good_ff, last_good_in;
   logic               large_ff, large_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        crc_ff, crc_in;
   logic [7:0]         hnum_ff, hnum_in;
   logic [7:0]         hcomp_ff, hcomp_in;
   logic [7:0]         crch_ff, crch_in;

   logic [COUNT_W:0]   count_plus;
   logic [COUNT_W:0]   block_size;
   logic [15:0]        crc_next;
   logic [7:0]         b;

   assign b          = item.rx_byte;
   assign count_plus = {1'b0, count_ff} + 1'b1;
   assign block_size = large_ff ? LARGE_PAYLOAD : SMALL_PAYLOAD;
   assign crc_next   = crc_add(crc_ff, b);

   always_comb begin
      phase_in     = phase_ff;
      last_good_in = last_good_ff;
      large_in     = large_ff;
      count_in     = count_ff;
      crc_in       = crc_ff;
      hnum_in      = hnum_ff;
      hcomp_in     = hcomp_ff;
      crch_in      = crch_ff;
      result       = '0;

      if (item.req_type == REQ_START) begin
         phase_in             = PH_WAIT;
         last_good_in         = 8'd0;
         count_in             = '0;
         crc_in               = 16'd0;
         result.valid         = 1'b1;
         result.item.out_kind = KIND_TX;
         result.item.out_byte = CH_C;
      end else begin
         case (phase_ff)
            PH_WAIT: begin
               if (b == CH_EOT) begin
                  phase_in             = PH_IDLE;
                  result.valid         = 1'b1;
                  result.item.out_kind = KIND_TX;
                  result.item.out_byte = CH_ACK;
                  result.item.verdict  = VERDICT_END;
               end else if (b == CH_SOH || b == CH_STX) begin
                  large_in = (b == CH_STX);
                  count_in = '0;
                  crc_in   = 16'd0;
                  phase_in = PH_NUM;
               end
            end
            PH_NUM: begin
               hnum_in  = b;
               phase_in = PH_COMP;
            end
            PH_COMP: begin
               hcomp_in = b;
               phase_in = PH_DATA;
            end
            PH_DATA: begin
               crc_in = crc_next;
               if (count_plus >= block_size) begin
                  count_in = '0;
                  phase_in = PH_CRCH;
               end else begin
                  count_in = count_plus[COUNT_W-1:0];
               end
               result.valid              = 1'b1;
               result.item.out_kind      = KIND_PAYLOAD;
               result.item.out_byte      = b;
               result.item.payload_index = count_ff;
               result.item.block_number  = hnum_ff;
            end
            PH_CRCH: begin
               crch_in  = b;
               phase_in = PH_CRCL;
            end
            PH_CRCL: begin
               count_in                 = '0;
               result.valid             = 1'b1;
               result.item.block_number = hnum_ff;
               // checks in protocol order: complement, duplicate, sequence, CRC
               if ((8'hFF - hnum_ff) != hcomp_ff) begin
                  phase_in            = PH_IDLE;
                  result.item.verdict = VERDICT_ABORT;
               end else if (hnum_ff == last_good_ff) begin
                  phase_in             = PH_WAIT;
                  result.item.out_kind = KIND_TX;
                  result.item.out_byte = CH_ACK;
                  result.item.verdict  = VERDICT_DUP;
               end else if (hnum_ff != last_good_ff + 8'd1) begin
                  phase_in            = PH_IDLE;
                  result.item.verdict = VERDICT_ABORT;
               end else if (crc_ff[15:8] != crch_ff || crc_ff[7:0] != b) begin
                  phase_in             = PH_WAIT;
                  result.item.out_kind = KIND_TX;
                  result.item.out_byte = CH_NAK;
                  result.item.verdict  = VERDICT_NAK;
               end else begin
                  last_good_in         = last_good_ff + 8'd1;
                  phase_in             = PH_WAIT;
                  result.item.out_kind = KIND_TX;
                  result.item.out_byte = CH_ACK;
                  result.item.verdict  = VERDICT_COMMIT;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         last_good_ff <= 8'd0;
         large_ff     <= 1'b0;
         count_ff     <= '0;
         crc_ff       <= 16'd0;
         hnum_ff      <= 8'd0;
         hcomp_ff     <= 8'd0;
         crch_ff      <= 8'd0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         last_good_ff <= last_good_in;
         large_ff     <= large_in;
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         hnum_ff      <= hnum_in;
         hcomp_ff     <= hcomp_in;
         crch_ff      <= crch_in;
      end
   end

`ifndef ASSERT_OFF
   // byte count is live only while a payload is streaming
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_DATA) |-> (count_ff == '0))
      else $error("byte count nonzero outside payload phase");

   a_small_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA && !large_ff) |-> (count_ff < SMALL_PAYLOAD[COUNT_W-1:0]))
      else $error("small block byte count out of range");

   a_abort_idle: assert property (@(posedge clock) disable iff (reset)
      (fire && result.valid && result.item.verdict == VERDICT_ABORT) |=>
      (phase_ff == PH_IDLE))
      else $error("abort did not end the session");
`endif

endmodule

### hdl/xbr_output_reg.sv
module xbr_output_reg
   import xbr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  step_result_type result,
   input  logic            load_req,
   output logic            can_load,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_item_type    rsp_data
);

   logic         valid_ff, valid_in;
   rsp_item_type data_ff;

   assign can_load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (can_load) begin
         valid_in = load_req && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (can_load && load_req && result.valid) begin
         data_ff <= result.item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### hdl/xmodem_block_receiver_unit.sv
// Each accepted request is held in the input register and its response in the result register.
// Throughput: one request transaction per cycle while rsp_stall does not hold the result register;
// the session step (CRC byte update, header checks, verdict) is one combinational pass between the two registers.
// A request that produces no response still passes through the core.
// Reset (synchronous, active high): pipeline empty, session idle, all session state zero.
module xmodem_block_receiver_unit
   import xbr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   // Stage 1: registered request transaction.
   logic         item_valid;
   req_item_type item;

   // Core step result feeding the output register.
   step_result_type result;

   // The held request advances whenever the result register can take a new value;
   // a request with no response advances the session state all the same.
   logic can_load;
   logic advance;

   assign advance = item_valid && can_load;

   xbr_input_reg u_input_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // Session state machine, CRC and verdict logic; state commits only on advance.
   xbr_session_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item),
      .result (result)
   );

   // Result register: keeps a stalled response while the next request is taken in.
   xbr_output_reg u_output_reg (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .load_req  (advance),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // With the result register free, the held request always moves on.
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      (item_valid && !rsp_valid) |-> !req_stall)
      else $error("request stalled with free result register");
`endif

endmodule
